// File: rtl/ssd_pkg.sv
// ssd_pkg: shared types, constants and the character-to-segment table
// for the seven-segment scan driver. No dependencies.
`default_nettype none

package ssd_pkg;

   // Field widths fixed by the interface
   localparam int unsigned CHAR_WIDTH   = 8;
   localparam int unsigned POS_WIDTH    = 3;
   localparam int unsigned SEG_WIDTH    = 7;
   localparam int unsigned ENABLE_WIDTH = 6;

   // Default digit count and the value every slot holds after reset ('0')
   localparam int unsigned DIGITS_DEFAULT = 6;
   localparam logic [CHAR_WIDTH-1:0] CHAR_RESET = 8'h30;

   // Segment pattern shown for characters not in the table (underscore)
   localparam logic [SEG_WIDTH-1:0] SEG_UNKNOWN = 7'h08;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_TICK  = 1'b1
   } opcode_type;

   // Control broadcast to every cell in the row
   typedef struct packed {
      logic                  tick;
      logic                  write;
      logic [POS_WIDTH-1:0]  pos;
      logic [CHAR_WIDTH-1:0] data;
   } cell_ctrl_type;

   // ASCII to segments a..g in bits 0..6
   function automatic logic [SEG_WIDTH-1:0] seg_of(input logic [CHAR_WIDTH-1:0] ch);
      logic [SEG_WIDTH-1:0] seg;
      unique case (ch)
         8'h20:                      seg = 7'h00; // space
         8'h2D:                      seg = 7'h40; // '-'
         8'h30:                      seg = 7'h3F;
         8'h31:                      seg = 7'h06;
         8'h32:                      seg = 7'h5B;
         8'h33:                      seg = 7'h4F;
         8'h34:                      seg = 7'h66;
         8'h35:                      seg = 7'h6D;
         8'h36:                      seg = 7'h7D;
         8'h37:                      seg = 7'h07;
         8'h38:                      seg = 7'h7F;
         8'h39:                      seg = 7'h6F;
         8'h41:                      seg = 7'h77; // A
         8'h61:                      seg = 7'h5F; // a
         8'h42, 8'h62:               seg = 7'h7C; // B b
         8'h43:                      seg = 7'h39; // C
         8'h63:                      seg = 7'h58; // c
         8'h44, 8'h45, 8'h65:        seg = 7'h79; // D E e (D shares E)
         8'h64:                      seg = 7'h5E; // d
         8'h46, 8'h66:               seg = 7'h71; // F f
         8'h48:                      seg = 7'h76; // H
         8'h68:                      seg = 7'h74; // h
         8'h49, 8'h69:               seg = 7'h30; // I i
         8'h4C, 8'h6C:               seg = 7'h38; // L l
         8'h4E, 8'h6E:               seg = 7'h54; // N n
         8'h4F:                      seg = 7'h3F; // O
         8'h6F:                      seg = 7'h5C; // o
         8'h50, 8'h70, 8'h51, 8'h71: seg = 7'h73; // P p Q q
         8'h52, 8'h72:               seg = 7'h50; // R r
         8'h53, 8'h73:               seg = 7'h6D; // S s
         8'h54, 8'h74:               seg = 7'h78; // T t
         8'h55:                      seg = 7'h3E; // U
         8'h75:                      seg = 7'h1C; // u
         8'h59, 8'h79:               seg = 7'h6E; // Y y
         default:                    seg = SEG_UNKNOWN;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

// File: rtl/ssd_cell.sv
// ssd_cell: one digit slot of the display row. Holds the slot's character
// and its bit of the circulating scan token. Depends on ssd_pkg.
`default_nettype none

module ssd_cell #(
   parameter int unsigned DIGITS = ssd_pkg::DIGITS_DEFAULT,
   parameter int unsigned SLOT   = 0
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire  ssd_pkg::cell_ctrl_type         ctrl,
   input  wire                                  token_in,
   output logic                                 token_out,
   input  wire  [ssd_pkg::CHAR_WIDTH-1:0]       char_in,
   output logic [ssd_pkg::CHAR_WIDTH-1:0]       char_out
);

   // String position that lands in this slot (string is stored reversed)
   localparam logic [ssd_pkg::POS_WIDTH-1:0] MyPos =
      ssd_pkg::POS_WIDTH'(DIGITS - 1 - SLOT);

   logic [ssd_pkg::CHAR_WIDTH-1:0] char_ff;
   logic                           token_ff;

   // Character store and token hand-off from the previous cell
   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff  <= ssd_pkg::CHAR_RESET;
         token_ff <= (SLOT == 0);
      end else begin
         if (ctrl.write && (ctrl.pos == MyPos)) begin
            char_ff <= ctrl.data;
         end
         if (ctrl.tick) begin
            token_ff <= token_in;
         end
      end
   end

   // Token arriving here marks the slot shown after the next tick
   assign token_out = token_ff;
   assign char_out  = char_in | (token_in ? char_ff : '0);

endmodule

`default_nettype wire

// File: rtl/seven_segment_scan_driver.sv
// seven_segment_scan_driver: multiplexed seven-segment display driver top.
// Instantiates a ring of ssd_cell slots; uses ssd_pkg types and table.
//
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | opcode, string_position, char_code
//   rsp     | out       | rsp_valid/stall   | segment_pattern, digit_enable, scan_index
//
// One item per cycle while req_stall is low. A tick's result appears in the
// cycle after its transfer, from the output register fed by the cell row and
// segment table. A write gives no result. Synchronous reset loads '0' into
// every slot and puts the scan token on slot 0. req_stall is high only while
// the output register holds a result that is stalled.
`default_nettype none

module seven_segment_scan_driver #(
   parameter int unsigned DIGITS = ssd_pkg::DIGITS_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire                                  req_opcode,
   input  wire  [ssd_pkg::POS_WIDTH-1:0]        req_string_position,
   input  wire  [ssd_pkg::CHAR_WIDTH-1:0]       req_char_code,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [ssd_pkg::SEG_WIDTH-1:0]        rsp_segment_pattern,
   output logic [ssd_pkg::ENABLE_WIDTH-1:0]     rsp_digit_enable,
   output logic [ssd_pkg::POS_WIDTH-1:0]        rsp_scan_index
);

   localparam int unsigned EnBits =
      (DIGITS < ssd_pkg::ENABLE_WIDTH) ? DIGITS : ssd_pkg::ENABLE_WIDTH;

   ssd_pkg::cell_ctrl_type         ctrl;
   logic                           req_accept;
   logic [DIGITS-1:0]              token;
   logic [DIGITS-1:0]              next_token;
   logic [ssd_pkg::CHAR_WIDTH-1:0] chain [DIGITS+1];

   logic [ssd_pkg::ENABLE_WIDTH-1:0] enable_in;
   logic [ssd_pkg::POS_WIDTH-1:0]    index_in;
   logic [ssd_pkg::SEG_WIDTH-1:0]    seg_in;

   logic                             valid_ff;
   logic [ssd_pkg::SEG_WIDTH-1:0]    seg_ff;
   logic [ssd_pkg::ENABLE_WIDTH-1:0] enable_ff;
   logic [ssd_pkg::POS_WIDTH-1:0]    index_ff;

   // Input transfer and control broadcast
   assign req_stall  = valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      ctrl.tick  = req_accept && (req_opcode == ssd_pkg::OP_TICK);
      ctrl.write = req_accept && (req_opcode == ssd_pkg::OP_WRITE);
      ctrl.pos   = req_string_position;
      ctrl.data  = req_char_code;
   end

   // Cell row: token ring, character select chain
   assign chain[0] = '0;

   for (genvar g = 0; g < DIGITS; g++) begin : g_cell
      localparam int unsigned Prev = (g + DIGITS - 1) % DIGITS;
      assign next_token[g] = token[Prev];
      ssd_cell #(
         .DIGITS (DIGITS),
         .SLOT   (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .token_in  (token[Prev]),
         .token_out (token[g]),
         .char_in   (chain[g]),
         .char_out  (chain[g+1])
      );
   end

   // Enable bits that fit the output field
   for (genvar e = 0; e < ssd_pkg::ENABLE_WIDTH; e++) begin : g_en
      if (e < EnBits) begin : g_on
         assign enable_in[e] = next_token[e];
      end else begin : g_off
         assign enable_in[e] = 1'b0;
      end
   end

   // Encode the next slot number and look up its segments
   always_comb begin
      index_in = '0;
      for (int i = 0; i < DIGITS; i++) begin
         index_in = index_in | (next_token[i] ? ssd_pkg::POS_WIDTH'(i) : '0);
      end
      seg_in = ssd_pkg::seg_of(chain[DIGITS]);
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.tick) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.tick) begin
         seg_ff    <= seg_in;
         enable_ff <= enable_in;
         index_ff  <= index_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_segment_pattern = seg_ff;
   assign rsp_digit_enable    = enable_ff;
   assign rsp_scan_index      = index_ff;

   // Exactly one cell holds the scan token
   a_token_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(token))
      else $error("scan token not one-hot");

   // A tick transfer always yields a result next cycle
   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      ctrl.tick |=> valid_ff)
      else $error("tick without result");

   // Reported slot stays within the digit count
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (index_ff < ssd_pkg::POS_WIDTH'(DIGITS - 1) ||
                    index_ff == ssd_pkg::POS_WIDTH'(DIGITS - 1)))
      else $error("scan index out of range");

   // Writes never disturb the scan token
   a_write_keeps_token: assert property (@(posedge clock) disable iff (reset)
      ctrl.write |=> $stable(token))
      else $error("write moved the scan token");

endmodule

`default_nettype wire

// File: bench/tb.sv
// tb: self-checking bench for seven_segment_scan_driver. Holds a scoreboard model
// of the character slots and scan position and checks every tick's segments, enable and index.
// Depends on ssd_pkg and the rtl top only.
`default_nettype none

module tb;

   localparam int unsigned DIGITS = ssd_pkg::DIGITS_DEFAULT;

   // One displayed digit as the block reports it after a tick
   typedef struct packed {
      logic [ssd_pkg::SEG_WIDTH-1:0]    segments;
      logic [ssd_pkg::ENABLE_WIDTH-1:0] enable;
      logic [ssd_pkg::POS_WIDTH-1:0]    slot;
   } digit_view_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   ssd_pkg::opcode_type              req_opcode = ssd_pkg::OP_WRITE;
   logic [ssd_pkg::POS_WIDTH-1:0]    req_string_position = '0;
   logic [ssd_pkg::CHAR_WIDTH-1:0]   req_char_code = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [ssd_pkg::SEG_WIDTH-1:0]    rsp_segment_pattern;
   logic [ssd_pkg::ENABLE_WIDTH-1:0] rsp_digit_enable;
   logic [ssd_pkg::POS_WIDTH-1:0]    rsp_scan_index;

   // Scoreboard copy of the display state
   logic [ssd_pkg::CHAR_WIDTH-1:0] slot_chars [DIGITS];
   logic [ssd_pkg::POS_WIDTH-1:0]  shown_slot;
   digit_view_type                 shown_digit_q [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatch_count = 0;

   string glyph_set = "0123456789 -AaBbCcDdEeFfHhIiLlNnOoPpQqRrSsTtUuYy";

   seven_segment_scan_driver #(.DIGITS(DIGITS)) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_string_position (req_string_position),
      .req_char_code       (req_char_code),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_segment_pattern (rsp_segment_pattern),
      .rsp_digit_enable    (rsp_digit_enable),
      .rsp_scan_index      (rsp_scan_index)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Segment lookup, a..g in bits 0..6; anything unlisted shows underscore
   function automatic logic [ssd_pkg::SEG_WIDTH-1:0] glyph_segments(
      input logic [ssd_pkg::CHAR_WIDTH-1:0] ch);
      case (ch)
         " ":                return 7'h00;
         "-":                return 7'h40;
         "0", "O":           return 7'h3F;
         "1":                return 7'h06;
         "2":                return 7'h5B;
         "3":                return 7'h4F;
         "4":                return 7'h66;
         "5", "S", "s":      return 7'h6D;
         "6":                return 7'h7D;
         "7":                return 7'h07;
         "8":                return 7'h7F;
         "9":                return 7'h6F;
         "A":                return 7'h77;
         "a":                return 7'h5F;
         "B", "b":           return 7'h7C;
         "C":                return 7'h39;
         "c":                return 7'h58;
         "D", "E", "e":      return 7'h79;
         "d":                return 7'h5E;
         "F", "f":           return 7'h71;
         "H":                return 7'h76;
         "h":                return 7'h74;
         "I", "i":           return 7'h30;
         "L", "l":           return 7'h38;
         "N", "n":           return 7'h54;
         "o":                return 7'h5C;
         "P", "p", "Q", "q": return 7'h73;
         "R", "r":           return 7'h50;
         "T", "t":           return 7'h78;
         "U":                return 7'h3E;
         "u":                return 7'h1C;
         "Y", "y":           return 7'h6E;
         default:            return ssd_pkg::SEG_UNKNOWN;
      endcase
   endfunction

   // Apply one accepted transfer to the scoreboard state
   task automatic advance_display(input ssd_pkg::opcode_type op,
                                  input logic [ssd_pkg::POS_WIDTH-1:0] pos,
                                  input logic [ssd_pkg::CHAR_WIDTH-1:0] ch);
      digit_view_type view;
      int unsigned next_slot;
      if (op == ssd_pkg::OP_WRITE) begin
         // positions past the last digit are dropped
         if (pos < DIGITS)
            slot_chars[DIGITS-1-pos] = ch;
      end else begin
         next_slot = shown_slot + 1;
         if (next_slot >= DIGITS)
            next_slot = 0;
         shown_slot = next_slot[ssd_pkg::POS_WIDTH-1:0];
         view.segments = glyph_segments(slot_chars[next_slot]);
         view.enable = ssd_pkg::ENABLE_WIDTH'((64'd1 << next_slot) & 64'h3F);
         view.slot = next_slot[ssd_pkg::POS_WIDTH-1:0];
         shown_digit_q.push_back(view);
      end
   endtask

   // Drive one item at the falling edge and hold it until its transfer
   task automatic transfer_item(input ssd_pkg::opcode_type op,
                                input logic [ssd_pkg::POS_WIDTH-1:0] pos,
                                input logic [ssd_pkg::CHAR_WIDTH-1:0] ch);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_opcode = op;
      req_string_position = pos;
      req_char_code = ch;
      do @(posedge clock); while (req_stall);
      advance_display(op, pos, ch);
      @(negedge clock);
   endtask

   function automatic logic [ssd_pkg::CHAR_WIDTH-1:0] pick_char();
      if ($urandom_range(0, 99) < 60)
         return glyph_set[$urandom_range(0, glyph_set.len() - 1)];
      return ssd_pkg::CHAR_WIDTH'($urandom_range(0, 255));
   endfunction

   // Receiver back-pressure, redrawn every cycle
   always @(negedge clock)
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);

   // Compare each result transfer with the oldest expected digit
   always @(posedge clock) begin
      digit_view_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (shown_digit_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result seg=%h en=%h idx=%0d", $time,
                     rsp_segment_pattern, rsp_digit_enable, rsp_scan_index);
         end else begin
            want = shown_digit_q.pop_front();
            if (rsp_segment_pattern !== want.segments) begin
               mismatch_count++;
               $display("%0t: segment_pattern expected %h actual %h", $time,
                        want.segments, rsp_segment_pattern);
            end
            if (rsp_digit_enable !== want.enable) begin
               mismatch_count++;
               $display("%0t: digit_enable expected %h actual %h", $time,
                        want.enable, rsp_digit_enable);
            end
            if (rsp_scan_index !== want.slot) begin
               mismatch_count++;
               $display("%0t: scan_index expected %0d actual %0d", $time,
                        want.slot, rsp_scan_index);
            end
         end
      end
   end

   // Every slot holds '0' after reset; a full scan also checks wraparound
   task automatic test_reset_contents();
      repeat (DIGITS) transfer_item(ssd_pkg::OP_TICK, '0, '0);
   endtask

   // Extreme codes, dropped positions and the shared D/E pattern
   task automatic test_edge_writes();
      transfer_item(ssd_pkg::OP_WRITE, 3'd0, 8'hFF);
      transfer_item(ssd_pkg::OP_WRITE, 3'd5, 8'h00);
      transfer_item(ssd_pkg::OP_WRITE, 3'd6, "A");
      transfer_item(ssd_pkg::OP_WRITE, 3'd7, "A");
      transfer_item(ssd_pkg::OP_WRITE, 3'd2, "D");
      transfer_item(ssd_pkg::OP_WRITE, 3'd3, "-");
      transfer_item(ssd_pkg::OP_WRITE, 3'd4, " ");
      transfer_item(ssd_pkg::OP_TICK, 3'd7, 8'hFF);
      repeat (DIGITS) transfer_item(ssd_pkg::OP_TICK, '0, '0);
   endtask

   // Mostly strings written from position 0 followed by a scan, with some raw noise mixed in
   task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                      input int items);
      int sent;
      int len;
      sent = 0;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      while (sent < items) begin
         if ($urandom_range(0, 99) < 65) begin
            len = $urandom_range(1, DIGITS);
            for (int p = 0; p < len; p++)
               transfer_item(ssd_pkg::OP_WRITE, ssd_pkg::POS_WIDTH'(p), pick_char());
            sent += len;
            len = $urandom_range(1, 2 * DIGITS);
            repeat (len) transfer_item(ssd_pkg::OP_TICK,
                                       ssd_pkg::POS_WIDTH'($urandom_range(0, 7)),
                                       ssd_pkg::CHAR_WIDTH'($urandom_range(0, 255)));
            sent += len;
         end else begin
            transfer_item(ssd_pkg::opcode_type'($urandom_range(0, 1)),
                          ssd_pkg::POS_WIDTH'($urandom_range(0, 7)),
                          ssd_pkg::CHAR_WIDTH'($urandom_range(0, 255)));
            sent++;
         end
      end
   endtask

   initial begin
      for (int k = 0; k < DIGITS; k++)
         slot_chars[k] = ssd_pkg::CHAR_RESET;
      shown_slot = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_contents();
      test_edge_writes();
      test_random_traffic(0, 0, 300);
      test_random_traffic(70, 0, 300);
      test_random_traffic(0, 70, 300);
      test_random_traffic(36, 36, 300);

      // drain: stop stalling, then wait out the queue
      req_valid = 1'b0;
      rsp_stall_pct = 0;
      while (shown_digit_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && shown_digit_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Watchdog
   initial begin
      #4000000;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
